// ----- design/vfcm_pkg.sv -----
// ----------------------------------------------------------------------------
// vfcm_pkg: shared types, constants and the cube-corner table of the mesher
// Face codes, job word between front and back, front state encoding.
// ----------------------------------------------------------------------------
package vfcm_pkg;

  localparam int IDX_W      = 12;
  localparam int POS_W      = 5;
  localparam int FACE_W     = 3;
  localparam int VERT_W     = 3;
  localparam int FACE_N     = 6;
  localparam int SIDE_DEF   = 16;
  localparam int QDEPTH_DEF = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MESH  = 1'b1;

  localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
  localparam logic [FACE_W-1:0] FACE_MX = 3'd1;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
  localparam logic [FACE_W-1:0] FACE_MY = 3'd3;
  localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
  localparam logic [FACE_W-1:0] FACE_MZ = 3'd5;

  localparam logic [VERT_W-1:0] VERT_FIRST = 3'd0;
  localparam logic [VERT_W-1:0] VERT_LAST  = 3'd5;

  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
    logic [FACE_N-1:0] mask;
  } mesh_job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV_Y,
    F_REM_Y,
    F_DIV_Z,
    F_REM_Z,
    F_READ,
    F_PUSH
  } front_state_t;

  // corner bits: [0] x, [1] y, [2] z
  function automatic logic [2:0] face_corner(input logic [FACE_W-1:0] f,
                                             input logic [VERT_W-1:0] v);
    logic [17:0] row;
    logic [2:0]  c;
    case (f)
      FACE_PX: row = {3'd3, 3'd1, 3'd5, 3'd5, 3'd7, 3'd3};
      FACE_MX: row = {3'd2, 3'd0, 3'd4, 3'd4, 3'd6, 3'd2};
      FACE_PY: row = {3'd2, 3'd3, 3'd7, 3'd7, 3'd6, 3'd2};
      FACE_MY: row = {3'd0, 3'd1, 3'd5, 3'd5, 3'd4, 3'd0};
      FACE_PZ: row = {3'd4, 3'd5, 3'd7, 3'd7, 3'd6, 3'd4};
      FACE_MZ: row = {3'd0, 3'd1, 3'd3, 3'd3, 3'd2, 3'd0};
      default: row = '0;
    endcase
    case (v)
      3'd0:    c = row[2:0];
      3'd1:    c = row[5:3];
      3'd2:    c = row[8:6];
      3'd3:    c = row[11:9];
      3'd4:    c = row[14:12];
      3'd5:    c = row[17:15];
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [FACE_W-1:0] first_face(input logic [FACE_N-1:0] mask);
    logic [FACE_W-1:0] r;
    r = FACE_PX;
    for (int i = FACE_N - 1; i >= 0; i--) begin
      if (mask[i]) begin
        r = FACE_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- design/voxel_face_culling_mesher.sv -----
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher: face-culled cube mesher over a SIDE^3 voxel grid
// Write word: stored at accept, next word taken the following cycle.
// Mesh word: input stalled through the coordinate split, the reads of self and
// six neighbours on one memory port and the push (longer while the job queue is
// full); then six vertices per open face, one per cycle while out_stall is low.
// Reset: sync active low, clears control; grid undefined.
// ----------------------------------------------------------------------------
module voxel_face_culling_mesher import vfcm_pkg::*; #(
  parameter int SIDE   = SIDE_DEF,
  parameter int QDEPTH = QDEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [IDX_W-1:0]  in_voxel_index,
  input  logic              in_solid,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [POS_W-1:0]  out_pos_x,
  output logic [POS_W-1:0]  out_pos_y,
  output logic [POS_W-1:0]  out_pos_z,
  output logic              out_tex_u,
  output logic              out_tex_v,
  output logic [FACE_W-1:0] out_face,
  output logic              out_last
);

  logic      q_push, q_full, q_pop, q_valid;
  mesh_job_t push_job, pop_job;

  vfcm_front #(
    .SIDE (SIDE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_voxel_index (in_voxel_index),
    .in_solid       (in_solid),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  vfcm_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .valid    (q_valid)
  );

  vfcm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y),
    .out_pos_z (out_pos_z),
    .out_tex_u (out_tex_u),
    .out_tex_v (out_tex_v),
    .out_face  (out_face),
    .out_last  (out_last)
  );

`ifndef SYNTHESIS
  a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  a_q_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job popped from empty queue");

  a_job_has_face: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> push_job.mask != '0)
    else $error("job without open face queued");

  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_face <= FACE_MZ)
    else $error("vertex with invalid face code");
`endif

endmodule

// ----- design/vfcm_front.sv -----
// ----------------------------------------------------------------------------
// vfcm_front: takes words, owns the voxel memory, classifies mesh requests
// Splits the index into coordinates, reads self and six neighbours, and
// pushes a job with the open-face mask if self is solid and a face is open.
// ----------------------------------------------------------------------------
module vfcm_front import vfcm_pkg::*; #(
  parameter int SIDE = SIDE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_op,
  input  logic [IDX_W-1:0] in_voxel_index,
  input  logic             in_solid,
  input  logic             q_full,
  output logic             q_push,
  output mesh_job_t        q_job
);

  localparam int GRID      = SIDE * SIDE * SIDE;
  localparam int SS        = SIDE * SIDE;
  localparam int IDX_SPAN  = 1 << IDX_W;
  localparam int MEM_DEPTH = (GRID < IDX_SPAN) ? GRID : IDX_SPAN;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int COORD_W   = $clog2(SIDE);
  localparam int RCP_W     = IDX_W + 1;
  localparam int PROD_W    = IDX_W + RCP_W;
  localparam int SH_SS     = IDX_W + $clog2(SS);
  localparam int SH_S      = IDX_W + $clog2(SIDE);
  localparam longint RCP_SS = ((longint'(1) << SH_SS) + longint'(SS) - 1) / longint'(SS);
  localparam longint RCP_S  = ((longint'(1) << SH_S) + longint'(SIDE) - 1) / longint'(SIDE);
  localparam logic [IDX_W-1:0]   SS_I      = IDX_W'(SS);
  localparam logic [IDX_W-1:0]   SIDE_I    = IDX_W'(SIDE);
  localparam logic [COORD_W-1:0] COORD_TOP = COORD_W'(SIDE - 1);
  localparam logic [2:0] RD_SELF  = 3'd0;
  localparam logic [2:0] RD_FIRST = 3'd2;
  localparam logic [2:0] RD_LAST  = 3'd7;

  front_state_t state_r, state_nxt;

  logic               acc;
  logic               in_range;
  logic               mem_we;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   rem_r;
  logic [COORD_W-1:0] x_r, y_r, z_r;
  logic [PROD_W-1:0]  prod_y, prod_z;
  logic [2:0]         cnt_r;
  logic [FACE_W-1:0]  rd_face, dat_face;
  logic [IDX_W-1:0]   nb_idx;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_data_r;
  logic               self_solid_r;
  logic [FACE_N-1:0]  mask_r;
  logic [FACE_N-1:0]  inner;
  logic               mem [MEM_DEPTH];

  assign acc      = in_valid && !in_stall;
  assign in_range = int'(in_voxel_index) < GRID;

  assign prod_y = PROD_W'(idx_r) * PROD_W'(RCP_SS);
  assign prod_z = PROD_W'(rem_r) * PROD_W'(RCP_S);

  assign rd_face  = cnt_r - 3'd1;
  assign dat_face = cnt_r - RD_FIRST;

  always_comb begin
    nb_idx = idx_r;
    if (cnt_r != RD_SELF) begin
      case (rd_face)
        FACE_PX: nb_idx = idx_r + IDX_W'(1);
        FACE_MX: nb_idx = idx_r - IDX_W'(1);
        FACE_PY: nb_idx = idx_r + SS_I;
        FACE_MY: nb_idx = idx_r - SS_I;
        FACE_PZ: nb_idx = idx_r + SIDE_I;
        FACE_MZ: nb_idx = idx_r - SIDE_I;
        default: nb_idx = idx_r;
      endcase
    end
  end

  assign rd_addr = ADDR_W'(nb_idx);

  assign inner[FACE_PX] = x_r != COORD_TOP;
  assign inner[FACE_MX] = x_r != '0;
  assign inner[FACE_PY] = y_r != COORD_TOP;
  assign inner[FACE_MY] = y_r != '0;
  assign inner[FACE_PZ] = z_r != COORD_TOP;
  assign inner[FACE_MZ] = z_r != '0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (acc && in_op == OP_MESH && in_range) begin
          state_nxt = F_DIV_Y;
        end
      end
      F_DIV_Y: state_nxt = F_REM_Y;
      F_REM_Y: state_nxt = F_DIV_Z;
      F_DIV_Z: state_nxt = F_REM_Z;
      F_REM_Z: state_nxt = F_READ;
      F_READ: begin
        if (cnt_r == RD_LAST) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!self_solid_r || mask_r == '0 || !q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    mem_we   = 1'b0;
    q_push   = 1'b0;
    case (state_r)
      F_IDLE: begin
        in_stall = 1'b0;
        mem_we   = in_valid && in_op == OP_WRITE && in_range;
      end
      F_PUSH: q_push = self_solid_r && mask_r != '0 && !q_full;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign q_job.x    = POS_W'(x_r);
  assign q_job.y    = POS_W'(y_r);
  assign q_job.z    = POS_W'(z_r);
  assign q_job.mask = mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= RD_SELF;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_READ) begin
        cnt_r <= cnt_r + 3'd1;
      end else begin
        cnt_r <= RD_SELF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      idx_r <= in_voxel_index;
    end
    if (state_r == F_DIV_Y) begin
      y_r <= COORD_W'(prod_y >> SH_SS);
    end
    if (state_r == F_REM_Y) begin
      rem_r <= idx_r - IDX_W'(int'(y_r) * SS);
    end
    if (state_r == F_DIV_Z) begin
      z_r <= COORD_W'(prod_z >> SH_S);
    end
    if (state_r == F_REM_Z) begin
      x_r <= COORD_W'(rem_r - IDX_W'(int'(z_r) * SIDE));
    end
    if (state_r == F_READ && cnt_r == RD_SELF + 3'd1) begin
      self_solid_r <= rd_data_r;
    end
    if (state_r == F_READ && cnt_r >= RD_FIRST) begin
      mask_r[dat_face] <= inner[dat_face] & ~rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ADDR_W'(in_voxel_index)] <= in_solid;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ----- design/vfcm_queue.sv -----
// ----------------------------------------------------------------------------
// vfcm_queue: short job queue between front and back
// Register-based ring buffer with occupancy count.
// ----------------------------------------------------------------------------
module vfcm_queue import vfcm_pkg::*; #(
  parameter int DEPTH = QDEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mesh_job_t push_job,
  output logic      full,
  input  logic      pop,
  output mesh_job_t pop_job,
  output logic      valid
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  mesh_job_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full    = cnt_r == CNT_MAX;
  assign valid   = cnt_r != '0;
  assign pop_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_TOP) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_TOP) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- design/vfcm_back.sv -----
// ----------------------------------------------------------------------------
// vfcm_back: vertex emitter
// Walks the open faces of one job, six vertices each, one per cycle unless the
// output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module vfcm_back import vfcm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  mesh_job_t         q_job,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [POS_W-1:0]  out_pos_x,
  output logic [POS_W-1:0]  out_pos_y,
  output logic [POS_W-1:0]  out_pos_z,
  output logic              out_tex_u,
  output logic              out_tex_v,
  output logic [FACE_W-1:0] out_face,
  output logic              out_last
);

  logic              busy_r;
  logic [FACE_N-1:0] mask_r, rest;
  logic [POS_W-1:0]  x_r, y_r, z_r;
  logic [VERT_W-1:0] vert_r;
  logic [FACE_W-1:0] face;
  logic [2:0]        corner;
  logic              emit, fin;
  logic              out_valid_r;
  logic [POS_W-1:0]  pos_x_r, pos_y_r, pos_z_r;
  logic              tex_u_r, tex_v_r, last_r;
  logic [FACE_W-1:0] face_r;

  assign face   = first_face(mask_r);
  assign corner = face_corner(face, vert_r);
  assign rest   = mask_r & ~(FACE_N'(1) << face);
  assign fin    = vert_r == VERT_LAST && rest == '0;
  assign emit   = busy_r && (!out_valid_r || !out_stall);
  assign q_pop  = q_valid && (!busy_r || (emit && fin));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
      end else if (emit && fin) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_r    <= q_job.x;
      y_r    <= q_job.y;
      z_r    <= q_job.z;
      mask_r <= q_job.mask;
      vert_r <= VERT_FIRST;
    end else if (emit) begin
      if (vert_r == VERT_LAST) begin
        vert_r <= VERT_FIRST;
        mask_r <= rest;
      end else begin
        vert_r <= vert_r + VERT_W'(1);
      end
    end
    if (emit) begin
      pos_x_r <= x_r + POS_W'(corner[0]);
      pos_y_r <= y_r + POS_W'(corner[1]);
      pos_z_r <= z_r + POS_W'(corner[2]);
      tex_u_r <= corner[0];
      tex_v_r <= corner[1];
      face_r  <= face;
      last_r  <= fin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = pos_x_r;
  assign out_pos_y = pos_y_r;
  assign out_pos_z = pos_z_r;
  assign out_tex_u = tex_u_r;
  assign out_tex_v = tex_v_r;
  assign out_face  = face_r;
  assign out_last  = last_r;

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for voxel_face_culling_mesher
// Fills voxels and meshes them, predicting every emitted vertex from a local
// copy of the grid. Directed corner, interior and empty-voxel cases come first,
// then clustered random writes and meshes under random idling and stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vfcm_pkg::*;

  localparam int SIDE_N   = SIDE_DEF;
  localparam int TOP      = SIDE_N - 1;
  localparam int PLANE    = SIDE_N * SIDE_N;
  localparam int CELLS    = SIDE_N * SIDE_N * SIDE_N;
  localparam int N_WORDS  = 350;
  localparam int IDLE_MAX = 4000;

  // corner bits per face and vertex: [0] x, [1] y, [2] z
  localparam logic [0:5][0:5][2:0] CORNERS = {
    3'd3, 3'd7, 3'd5, 3'd5, 3'd1, 3'd3,
    3'd2, 3'd6, 3'd4, 3'd4, 3'd0, 3'd2,
    3'd2, 3'd6, 3'd7, 3'd7, 3'd3, 3'd2,
    3'd0, 3'd4, 3'd5, 3'd5, 3'd1, 3'd0,
    3'd4, 3'd6, 3'd7, 3'd7, 3'd5, 3'd4,
    3'd0, 3'd2, 3'd3, 3'd3, 3'd1, 3'd0
  };

  typedef struct {
    logic             op;
    logic [IDX_W-1:0] idx;
    logic             solid;
    bit               pause;
  } voxel_word_t;

  typedef struct {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
    logic              u;
    logic              v;
    logic [FACE_W-1:0] face;
    logic              last;
  } vertex_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_op = OP_WRITE;
  logic [IDX_W-1:0]  in_voxel_index = '0;
  logic              in_solid = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [POS_W-1:0]  out_pos_x;
  logic [POS_W-1:0]  out_pos_y;
  logic [POS_W-1:0]  out_pos_z;
  logic              out_tex_u;
  logic              out_tex_v;
  logic [FACE_W-1:0] out_face;
  logic              out_last;

  voxel_word_t word_q[$];
  vertex_t     vertex_q[$];
  bit          voxel_bits [CELLS];
  bit          made [CELLS];
  int          n_words;
  int          n_taken;
  int          errors;
  int          idle_cycles;
  logic        in_fire_q = 1'b0;
  int          burst_left;
  int          gap_left;
  int          hold_left;
  bit          hold_done;
  logic [9:0]  rx_tick = '0;
  voxel_word_t tx_word;

  voxel_face_culling_mesher uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_voxel_index (in_voxel_index),
    .in_solid       (in_solid),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_pos_z      (out_pos_z),
    .out_tex_u      (out_tex_u),
    .out_tex_v      (out_tex_v),
    .out_face       (out_face),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idx_of(int x, int y, int z);
    return x + z * SIDE_N + y * PLANE;
  endfunction

  // index of the neighbor across a face, -1 when it lies outside the chunk
  function automatic int neighbor_idx(int c, int f);
    int x, y, z;
    x = c % SIDE_N;
    z = (c / SIDE_N) % SIDE_N;
    y = c / PLANE;
    case (f)
      FACE_PX: return (x < TOP) ? c + 1 : -1;
      FACE_MX: return (x > 0) ? c - 1 : -1;
      FACE_PY: return (y < TOP) ? c + PLANE : -1;
      FACE_MY: return (y > 0) ? c - PLANE : -1;
      FACE_PZ: return (z < TOP) ? c + SIDE_N : -1;
      FACE_MZ: return (z > 0) ? c - SIDE_N : -1;
      default: return -1;
    endcase
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return TOP;
      default: return $urandom_range(0, TOP);
    endcase
  endfunction

  task automatic push_write(int idx, bit s);
    voxel_word_t w;
    w = '{op: OP_WRITE, idx: IDX_W'(idx), solid: s, pause: 1'b0};
    word_q.push_back(w);
    made[idx] = 1'b1;
    n_words++;
  endtask

  // any voxel the mesh may look at gets written first
  task automatic push_mesh(int idx);
    int near [7];
    voxel_word_t w;
    near = '{idx, idx + 1, idx - 1, idx + SIDE_N, idx - SIDE_N, idx + PLANE, idx - PLANE};
    foreach (near[i]) begin
      if (near[i] >= 0 && near[i] < CELLS && !made[near[i]]) begin
        push_write(near[i], 1'($urandom_range(0, 1)));
      end
    end
    w = '{op: OP_MESH, idx: IDX_W'(idx), solid: 1'($urandom_range(0, 1)), pause: 1'b0};
    word_q.push_back(w);
    n_words++;
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic isolated_voxel(int c);
    push_write(c, 1'b1);
    for (int f = 0; f < FACE_N; f++) begin
      if (neighbor_idx(c, f) >= 0) begin
        push_write(neighbor_idx(c, f), 1'b0);
      end
    end
    push_mesh(c);
  endtask

  // input driver: bursts and gaps, one pause until all vertices are back
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
    end else if (in_valid && !in_fire_q) begin
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (word_q.size() == 0) begin
      in_valid <= 1'b0;
    end else if (word_q[0].pause) begin
      in_valid <= 1'b0;
      if (vertex_q.size() == 0) begin
        void'(word_q.pop_front());
      end
    end else begin
      tx_word = word_q.pop_front();
      in_op          <= tx_word.op;
      in_voxel_index <= tx_word.idx;
      in_solid       <= tx_word.solid;
      in_valid       <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        case ($urandom_range(0, 9))
          0, 1, 2: gap_left <= 0;
          8, 9:    gap_left <= $urandom_range(5, 30);
          default: gap_left <= $urandom_range(1, 4);
        endcase
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // result stall pattern, with one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1'b1;
      if (!hold_done && n_taken >= 100) begin
        hold_left <= 400;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (rx_tick[9:8])
          2'd0:    out_stall <= 1'b0;
          2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
          2'd2:    out_stall <= (rx_tick[2:0] < 3'd3);
          default: out_stall <= ($urandom_range(0, 1) == 1);
        endcase
      end
    end
  end

  // accept-side prediction and result checking
  always @(posedge clk) begin : monitor
    int c, x, y, z, nb, cnt;
    logic [2:0] cr;
    vertex_t vt;
    if (!rst_n) begin
      in_fire_q <= 1'b0;
    end else begin
      in_fire_q <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        n_taken <= n_taken + 1;
        c = int'(in_voxel_index);
        if (in_op == OP_WRITE) begin
          voxel_bits[c] = in_solid;
        end else if (voxel_bits[c]) begin
          x = c % SIDE_N;
          z = (c / SIDE_N) % SIDE_N;
          y = c / PLANE;
          cnt = 0;
          for (int f = 0; f < FACE_N; f++) begin
            nb = neighbor_idx(c, f);
            if (nb >= 0 && !voxel_bits[nb]) begin
              for (int v = 0; v < 6; v++) begin
                cr = CORNERS[f][v];
                vt.x    = POS_W'(x + cr[0]);
                vt.y    = POS_W'(y + cr[1]);
                vt.z    = POS_W'(z + cr[2]);
                vt.u    = cr[0];
                vt.v    = cr[1];
                vt.face = FACE_W'(f);
                vt.last = 1'b0;
                vertex_q.push_back(vt);
                cnt++;
              end
            end
          end
          if (cnt > 0) begin
            vertex_q[vertex_q.size() - 1].last = 1'b1;
          end
        end
      end
      if (out_valid && !out_stall) begin
        if (vertex_q.size() == 0) begin
          $error("vertex word with none expected: pos %0d,%0d,%0d face %0d",
                 out_pos_x, out_pos_y, out_pos_z, out_face);
          errors++;
        end else begin
          vt = vertex_q.pop_front();
          compare_field("pos_x", vt.x, out_pos_x);
          compare_field("pos_y", vt.y, out_pos_y);
          compare_field("pos_z", vt.z, out_pos_z);
          compare_field("tex_u", vt.u, out_tex_u);
          compare_field("tex_v", vt.v, out_tex_v);
          compare_field("face", vt.face, out_face);
          compare_field("last", vt.last, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_MAX) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int c, nb, f;
    bit paused;
    voxel_word_t pw;
    // corners of the chunk, a fully exposed voxel, a fully buried one, an empty one
    isolated_voxel(0);
    isolated_voxel(CELLS - 1);
    c = idx_of(8, 8, 8);
    isolated_voxel(c);
    for (f = 0; f < FACE_N; f++) begin
      push_write(neighbor_idx(c, f), 1'b1);
    end
    push_mesh(c);
    push_write(c, 1'b0);
    push_mesh(c);

    paused = 1'b0;
    while (n_words < N_WORDS) begin
      if (!paused && n_words >= 200) begin
        pw = '{op: OP_WRITE, idx: '0, solid: 1'b0, pause: 1'b1};
        word_q.push_back(pw);
        paused = 1'b1;
      end
      case ($urandom_range(0, 9))
        7, 8: push_write($urandom_range(0, CELLS - 1), 1'($urandom_range(0, 1)));
        9:    push_mesh($urandom_range(0, CELLS - 1));
        default: begin
          c = idx_of(pick_coord(), pick_coord(), pick_coord());
          push_write(c, $urandom_range(0, 4) != 0);
          for (f = 0; f < FACE_N; f++) begin
            nb = neighbor_idx(c, f);
            if (nb >= 0) begin
              push_write(nb, $urandom_range(0, 99) < 45);
            end
          end
          push_mesh(c);
          if ($urandom_range(0, 2) == 0) begin
            nb = neighbor_idx(c, $urandom_range(0, FACE_N - 1));
            push_mesh((nb >= 0) ? nb : c);
          end
        end
      endcase
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    do begin
      @(posedge clk);
    end while (!(word_q.size() == 0 && !in_valid && vertex_q.size() == 0));
    repeat (60) @(posedge clk);
    if (errors == 0 && vertex_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
